FILE: sv/orzc_pkg.sv
// shared constants, code table and types for the range zone classifier
package orzc_pkg;

    localparam int OVERSAMPLE_LOG2 = 4;

    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 20;
    localparam int COUNT_W    = 9;
    localparam int TABLE_SIZE = 14;
    localparam int IDX_W      = 4;
    localparam int ZONE_W     = 2;
    localparam int MID_W      = SAMPLE_W + 1;

    localparam logic [COUNT_W-1:0] OVERSAMPLE_N    = COUNT_W'(1 << OVERSAMPLE_LOG2);
    localparam logic [COUNT_W-1:0] OVERSAMPLE_LAST = COUNT_W'((1 << OVERSAMPLE_LOG2) - 1);

    // at or below this average the target is too far away
    localparam logic [SAMPLE_W-1:0] FAR_LIMIT = SAMPLE_W'(434);

    // last table index of each led zone
    localparam logic [IDX_W-1:0] GREEN_LAST_IDX = IDX_W'(4);
    localparam logic [IDX_W-1:0] RED_LAST_IDX   = IDX_W'(8);
    localparam logic [IDX_W-1:0] NEAR_IDX       = IDX_W'(0);
    localparam logic [IDX_W-1:0] MAX_IDX        = IDX_W'(TABLE_SIZE - 1);

    // led zone codes: bit0 green, bit1 red
    localparam logic [ZONE_W-1:0] LED_OFF  = 2'd0;
    localparam logic [ZONE_W-1:0] LED_NEAR = 2'd1;
    localparam logic [ZONE_W-1:0] LED_MID  = 2'd2;
    localparam logic [ZONE_W-1:0] LED_FAR  = 2'd3;

    // converter codes of the sensor curve, descending voltage
    localparam logic [SAMPLE_W-1:0] ZONE_CODES [TABLE_SIZE] = '{
        12'd3785, 12'd2246, 12'd1750, 12'd1588, 12'd1377, 12'd1179, 12'd1030,
        12'd831,  12'd757,  12'd695,  12'd633,  12'd571,  12'd521,  12'd459
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] average_code;
        logic [IDX_W-1:0]    nearest_index;
        logic                range_fault;
        logic [ZONE_W-1:0]   led_zone;
    } result_t;

    // sum of two neighboring codes, i.e. twice the decision midpoint
    function automatic logic [MID_W-1:0] mid_sum(input int unsigned i);
        mid_sum = MID_W'(ZONE_CODES[i]) + MID_W'(ZONE_CODES[i + 1]);
    endfunction

endpackage

FILE: sv/oversampled_range_zone_classifier_unit.sv
// top level of the oversampled range zone classifier
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  sample[11:0]
// out      output     out_valid/out_stall  average_code[11:0], nearest_index[3:0],
//                                          range_fault, led_zone[1:0]
//
// one sample item is taken every cycle while in_stall is low; every 2^OVERSAMPLE_LOG2
// items yield one result; the last sample of a group is taken into the input register,
// the mean into the accumulator/average register, then into the classify result register
// the accumulator add and the 13 constant midpoint compares set the rate
// rst_n clears the running sum, the sample count and all stage valid bits
// out_stall holds the result register; in_stall rises only once every stage is full
module oversampled_range_zone_classifier_unit
    import orzc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SAMPLE_W-1:0] average_code,
    output logic [IDX_W-1:0]    nearest_index,
    output logic                range_fault,
    output logic [ZONE_W-1:0]   led_zone
);

    // average hand-off between accumulator and classifier
    logic                avg_valid;
    logic [SAMPLE_W-1:0] avg_code;
    logic                avg_take;
    result_t             result;

    // sums samples, emits the truncated mean at the end of each group
    orzc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .avg_valid (avg_valid),
        .avg_code  (avg_code),
        .avg_take  (avg_take)
    );

    // maps the mean onto the distance table and the led zones
    orzc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .avg_valid (avg_valid),
        .avg_code  (avg_code),
        .avg_take  (avg_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign average_code  = result.average_code;
    assign nearest_index = result.nearest_index;
    assign range_fault   = result.range_fault;
    assign led_zone      = result.led_zone;

endmodule

FILE: sv/orzc_accum.sv
// input register and oversampling accumulator producing the average
module orzc_accum
    import orzc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                avg_valid,
    output logic [SAMPLE_W-1:0] avg_code,
    input  logic                avg_take
);

    logic                in_valid_reg, in_valid_next;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                avg_valid_reg, avg_valid_next;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SUM_W-1:0]    sum_add;
    logic                done;
    logic                avg_free;
    logic                in_take;
    logic                in_accept;

    assign sum_add   = sum_reg + SUM_W'(in_sample_reg);
    assign done      = (count_reg == OVERSAMPLE_LAST);
    assign avg_free  = !avg_valid_reg || avg_take;
    assign in_take   = in_valid_reg && (!done || avg_free);
    assign in_stall  = in_valid_reg && !in_take;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        avg_valid_next = avg_valid_reg;
        if (avg_take)
        begin
            avg_valid_next = 1'b0;
        end
        if (in_take)
        begin
            in_valid_next = 1'b0;
            if (done)
            begin
                sum_next       = '0;
                count_next     = '0;
                avg_valid_next = 1'b1;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_reg + COUNT_W'(1);
            end
        end
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_sample_reg <= sample;
        end
        if (in_take && done)
        begin
            avg_reg <= sum_add[OVERSAMPLE_LOG2 +: SAMPLE_W];
        end
    end

    assign avg_valid = avg_valid_reg;
    assign avg_code  = avg_reg;

`ifndef SYNTHESIS
    a_count_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < OVERSAMPLE_N)
        else $error("sample count reached the oversampling length");

    a_sum_clear_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("sum not cleared with an empty count");

    a_avg_held: assert property (@(posedge clk) disable iff (!rst_n)
        (avg_valid_reg && !avg_take) |=> (avg_valid_reg && $stable(avg_reg)))
        else $error("pending average lost or changed");
`endif

endmodule

FILE: sv/orzc_classify.sv
// nearest table entry, range flag, led zone and result register
module orzc_classify
    import orzc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                avg_valid,
    input  logic [SAMPLE_W-1:0] avg_code,
    output logic                avg_take,
    output logic                out_valid,
    input  logic                out_stall,
    output result_t             result
);

    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;
    logic [MID_W-1:0]       avg_x2;
    logic [TABLE_SIZE-2:0]  past_mid;
    logic [IDX_W-1:0]       idx;
    logic                   oor;

    assign avg_take = avg_valid && (!out_valid_reg || !out_stall);
    assign avg_x2   = {avg_code, 1'b0};

    // table descends, so the nearest index is the count of midpoints above the average;
    // a tie at a midpoint keeps the lower index
    always_comb
    begin
        for (int i = 0; i < TABLE_SIZE - 1; i++)
        begin
            past_mid[i] = (avg_x2 < mid_sum(i));
        end
    end

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < TABLE_SIZE - 1; i++)
        begin
            idx = idx + IDX_W'(past_mid[i]);
        end
    end

    assign oor = (idx == NEAR_IDX) || (avg_code <= FAR_LIMIT);

    always_comb
    begin
        result_next.average_code  = avg_code;
        result_next.nearest_index = idx;
        result_next.range_fault   = oor;
        if (oor)
        begin
            result_next.led_zone = LED_OFF;
        end
        else if (idx <= GREEN_LAST_IDX)
        begin
            result_next.led_zone = LED_NEAR;
        end
        else if (idx <= RED_LAST_IDX)
        begin
            result_next.led_zone = LED_MID;
        end
        else
        begin
            result_next.led_zone = LED_FAR;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (avg_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    a_oor_led_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.range_fault) |-> (result_reg.led_zone == LED_OFF))
        else $error("led zone lit while out of range");

    a_near_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.nearest_index == NEAR_IDX))
            |-> result_reg.range_fault)
        else $error("nearest entry zero not flagged");

    a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.nearest_index <= MAX_IDX))
        else $error("nearest index beyond table");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(result_reg)))
        else $error("stalled result changed");
`endif

endmodule
